>>> design/assert_macros.svh
// Assertion macros used by the checker file of the cache model.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> design/mhm_pkg.sv
// Shared constants and types of the two-level cache hit/miss model.
package mhm_pkg;

  // Geometry of the model.
  localparam int MAX_WAYS            = 4;
  localparam int FIRST_MAX_SET_BITS  = 6;
  localparam int SECOND_MAX_SET_BITS = 8;
  localparam int BLOCK_WORD_BITS     = 2;

  localparam int ADDR_W  = 32;
  localparam int BLK_W   = ADDR_W - 2 - BLOCK_WORD_BITS;
  localparam int TAG_W   = 30;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = 3;
  localparam int FIRST_ROWS  = 1 << FIRST_MAX_SET_BITS;
  localparam int SECOND_ROWS = 1 << SECOND_MAX_SET_BITS;

  localparam int CFG_W    = 10;
  localparam int CYCLE_W  = 48;
  localparam int COUNT_W  = 40;
  localparam int ADDED_W  = 11;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LEVEL_COUNT    = 3'd0,
    REG_L1_SET_BITS    = 3'd1,
    REG_L1_WAYS        = 3'd2,
    REG_L2_SET_BITS    = 3'd3,
    REG_L2_WAYS        = 3'd4,
    REG_L1_LATENCY     = 3'd5,
    REG_L2_LATENCY     = 3'd6,
    REG_MEMORY_LATENCY = 3'd7
  } reg_index_t;

  // Hit level codes.
  localparam logic [1:0] HIT_FIRST  = 2'd0;
  localparam logic [1:0] HIT_SECOND = 2'd1;
  localparam logic [1:0] HIT_NONE   = 2'd2;

  // One cache line and one set of lines, stored as a memory row.
  typedef struct packed {
    logic              recent;
    logic              valid;
    logic [TAG_W-1:0]  tag;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic process;
  } cmd_t;

endpackage

>>> design/mhm_ram.sv
// Generic single-port-write, registered-read RAM.
module mhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/mhm_ctrl.sv
// Controller state machine that sequences one access through read and write-back.
module mhm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output mhm_pkg::cmd_t cmd
);

  typedef enum logic {ST_IDLE, ST_LOOK} state_t;

  state_t state;

  // Commands follow the state directly.
  assign busy        = (state == ST_LOOK);
  assign cmd.capture = start && (state == ST_IDLE);
  assign cmd.process = (state == ST_LOOK);

  // State and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_LOOK);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/mhm_datapath.sv
// Datapath: configuration, tag memories, lookup, fill and running totals.
module mhm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mhm_pkg::cmd_t                       cmd,
  input  logic [mhm_pkg::ADDR_W-1:0]          byte_address,
  input  logic                                cfg_write,
  input  logic [2:0]                          cfg_index,
  input  logic [mhm_pkg::CFG_W-1:0]           cfg_data,
  output logic [1:0]                          hit_level,
  output logic [mhm_pkg::ADDED_W-1:0]         cycles_added,
  output logic [mhm_pkg::CYCLE_W-1:0]         total_cycles,
  output logic [mhm_pkg::COUNT_W-1:0]         first_hits,
  output logic [mhm_pkg::COUNT_W-1:0]         first_misses,
  output logic [mhm_pkg::COUNT_W-1:0]         second_hits,
  output logic [mhm_pkg::COUNT_W-1:0]         second_misses
);

  localparam int SET1_W = mhm_pkg::FIRST_MAX_SET_BITS;
  localparam int SET2_W = mhm_pkg::SECOND_MAX_SET_BITS;

  typedef struct packed {
    logic                      hit;
    logic [mhm_pkg::WAY_W-1:0] way;
  } find_t;

  // Make one way the only recent way of the set, when the set has several ways.
  function automatic mhm_pkg::row_t mark(mhm_pkg::row_t r,
                                         logic [mhm_pkg::WCNT_W-1:0] ways,
                                         logic [mhm_pkg::WAY_W-1:0] way);
    mhm_pkg::row_t o;
    o = r;
    if (ways != mhm_pkg::WCNT_W'(1)) begin
      for (int k = 0; k < mhm_pkg::MAX_WAYS; k++) begin
        if (ways > mhm_pkg::WCNT_W'(k)) begin
          o[k].recent = 1'b0;
        end
      end
      o[way].recent = 1'b1;
    end
    return o;
  endfunction

  // Scan the ways in order; an invalid way ends the search.
  function automatic find_t lookup(mhm_pkg::row_t r, logic [mhm_pkg::WCNT_W-1:0] ways,
                                   logic [mhm_pkg::TAG_W-1:0] tag);
    find_t f;
    logic  stop;
    f    = '0;
    stop = 1'b0;
    for (int j = 0; j < mhm_pkg::MAX_WAYS; j++) begin
      if (!stop && ways > mhm_pkg::WCNT_W'(j)) begin
        if (!r[j].valid) begin
          stop = 1'b1;
        end else if (r[j].tag == tag) begin
          f.hit = 1'b1;
          f.way = mhm_pkg::WAY_W'(j);
          stop  = 1'b1;
        end
      end
    end
    return f;
  endfunction

  // Place a tag into the set: a fresh invalid way first, else the first non-recent way.
  function automatic mhm_pkg::row_t fill(mhm_pkg::row_t r,
                                         logic [mhm_pkg::WCNT_W-1:0] ways,
                                         logic [mhm_pkg::TAG_W-1:0] tag);
    mhm_pkg::row_t             o;
    logic                      stop;
    logic                      present;
    logic                      found;
    logic [mhm_pkg::WAY_W-1:0] way;
    o       = r;
    stop    = 1'b0;
    present = 1'b0;
    found   = 1'b0;
    way     = '0;
    for (int j = 0; j < mhm_pkg::MAX_WAYS; j++) begin
      if (!stop && ways > mhm_pkg::WCNT_W'(j)) begin
        if (r[j].valid && r[j].tag == tag) begin
          present = 1'b1;
          stop    = 1'b1;
        end else if (!r[j].recent && !r[j].valid) begin
          found = 1'b1;
          way   = mhm_pkg::WAY_W'(j);
          stop  = 1'b1;
        end
      end
    end
    if (!present && !found) begin
      for (int j = mhm_pkg::MAX_WAYS - 1; j >= 0; j--) begin
        if (ways > mhm_pkg::WCNT_W'(j) && !r[j].recent) begin
          found = 1'b1;
          way   = mhm_pkg::WAY_W'(j);
        end
      end
    end
    if (!present && found) begin
      o[way].valid = 1'b1;
      o[way].tag   = tag;
      o            = mark(o, ways, way);
    end
    return o;
  endfunction

  // Configuration registers.
  logic [1:0] level_count;
  logic [2:0] l1_set_bits;
  logic [2:0] l1_ways;
  logic [3:0] l2_set_bits;
  logic [2:0] l2_ways;
  logic [7:0] l1_latency;
  logic [7:0] l2_latency;
  logic [9:0] memory_latency;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count    <= 2'd1;
      l1_set_bits    <= 3'd6;
      l1_ways        <= 3'd1;
      l2_set_bits    <= 4'd8;
      l2_ways        <= 3'd1;
      l1_latency     <= 8'd1;
      l2_latency     <= 8'd10;
      memory_latency <= 10'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mhm_pkg::REG_LEVEL_COUNT:    level_count    <= cfg_data[1:0];
        mhm_pkg::REG_L1_SET_BITS:    l1_set_bits    <= cfg_data[2:0];
        mhm_pkg::REG_L1_WAYS:        l1_ways        <= cfg_data[2:0];
        mhm_pkg::REG_L2_SET_BITS:    l2_set_bits    <= cfg_data[3:0];
        mhm_pkg::REG_L2_WAYS:        l2_ways        <= cfg_data[2:0];
        mhm_pkg::REG_L1_LATENCY:     l1_latency     <= cfg_data[7:0];
        mhm_pkg::REG_L2_LATENCY:     l2_latency     <= cfg_data[7:0];
        mhm_pkg::REG_MEMORY_LATENCY: memory_latency <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturated geometry.
  logic [2:0]                  sb1;
  logic [3:0]                  sb2;
  logic [mhm_pkg::WCNT_W-1:0]  ways1;
  logic [mhm_pkg::WCNT_W-1:0]  ways2;
  logic                        l1_on;
  logic                        l2_on;

  assign sb1   = (l1_set_bits > 3'(SET1_W)) ? 3'(SET1_W) : l1_set_bits;
  assign sb2   = (l2_set_bits > 4'(SET2_W)) ? 4'(SET2_W) : l2_set_bits;
  assign ways1 = (l1_ways > mhm_pkg::WCNT_W'(mhm_pkg::MAX_WAYS)) ?
                 mhm_pkg::WCNT_W'(mhm_pkg::MAX_WAYS) : l1_ways;
  assign ways2 = (l2_ways > mhm_pkg::WCNT_W'(mhm_pkg::MAX_WAYS)) ?
                 mhm_pkg::WCNT_W'(mhm_pkg::MAX_WAYS) : l2_ways;
  assign l1_on = (level_count != 2'd0);
  assign l2_on = (level_count[1] == 1'b1);

  // Set indexes of the incoming address, used for the memory read.
  logic [mhm_pkg::BLK_W-1:0] blk_in;
  logic [SET1_W-1:0]         set1_in;
  logic [SET2_W-1:0]         set2_in;

  assign blk_in  = mhm_pkg::BLK_W'(byte_address >> (2 + mhm_pkg::BLOCK_WORD_BITS));
  assign set1_in = SET1_W'(blk_in) & ~({SET1_W{1'b1}} << sb1);
  assign set2_in = SET2_W'(blk_in) & ~({SET2_W{1'b1}} << sb2);

  // Access registers and per-row valid bits.
  logic [mhm_pkg::BLK_W-1:0]   blk_q;
  logic [SET1_W-1:0]           set1_q;
  logic [SET2_W-1:0]           set2_q;
  logic                        v1_q;
  logic                        v2_q;
  logic [mhm_pkg::FIRST_ROWS-1:0]  row1_valid;
  logic [mhm_pkg::SECOND_ROWS-1:0] row2_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk_q  <= blk_in;
      set1_q <= set1_in;
      set2_q <= set2_in;
      v1_q   <= row1_valid[set1_in];
      v2_q   <= row2_valid[set2_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row1_valid <= '0;
      row2_valid <= '0;
    end else if (cmd.process) begin
      row1_valid[set1_q] <= 1'b1;
      row2_valid[set2_q] <= 1'b1;
    end
  end

  // Tag memories, one row per set.
  mhm_pkg::row_t rd1;
  mhm_pkg::row_t rd2;
  mhm_pkg::row_t wr1;
  mhm_pkg::row_t wr2;

  mhm_ram #(
    .WIDTH ($bits(mhm_pkg::row_t)),
    .DEPTH (mhm_pkg::FIRST_ROWS)
  ) u_first_ram (
    .clk     (clk),
    .wr_en   (cmd.process),
    .wr_addr (set1_q),
    .wr_data (wr1),
    .rd_en   (cmd.capture),
    .rd_addr (set1_in),
    .rd_data (rd1)
  );

  mhm_ram #(
    .WIDTH ($bits(mhm_pkg::row_t)),
    .DEPTH (mhm_pkg::SECOND_ROWS)
  ) u_second_ram (
    .clk     (clk),
    .wr_en   (cmd.process),
    .wr_addr (set2_q),
    .wr_data (wr2),
    .rd_en   (cmd.capture),
    .rd_addr (set2_in),
    .rd_data (rd2)
  );

  // Lookup in both levels and compute the rows to write back.
  mhm_pkg::row_t             row1;
  mhm_pkg::row_t             row2;
  logic [mhm_pkg::TAG_W-1:0] tag1;
  logic [mhm_pkg::TAG_W-1:0] tag2;
  find_t                     lk1;
  find_t                     lk2;
  logic                      hit1;
  logic                      hit2;

  assign row1 = v1_q ? rd1 : '0;
  assign row2 = v2_q ? rd2 : '0;
  assign tag1 = mhm_pkg::TAG_W'(blk_q >> sb1);
  assign tag2 = mhm_pkg::TAG_W'(blk_q >> sb2);
  assign lk1  = lookup(row1, ways1, tag1);
  assign lk2  = lookup(row2, ways2, tag2);
  assign hit1 = l1_on && lk1.hit;
  assign hit2 = l2_on && !hit1 && lk2.hit;

  always_comb begin
    wr1 = row1;
    wr2 = row2;
    if (l1_on) begin
      wr1 = hit1 ? mark(row1, ways1, lk1.way) : fill(row1, ways1, tag1);
    end
    if (l2_on && !hit1) begin
      wr2 = hit2 ? mark(row2, ways2, lk2.way) : fill(row2, ways2, tag2);
    end
  end

  // Charge for this access.
  logic [mhm_pkg::ADDED_W-1:0] added;
  logic [1:0]                  level;
  logic [mhm_pkg::CYCLE_W:0]   total_sum;

  always_comb begin
    if (!l1_on) begin
      added = mhm_pkg::ADDED_W'(memory_latency);
      level = mhm_pkg::HIT_NONE;
    end else if (hit1) begin
      added = mhm_pkg::ADDED_W'(l1_latency);
      level = mhm_pkg::HIT_FIRST;
    end else if (hit2) begin
      added = mhm_pkg::ADDED_W'(memory_latency);
      level = mhm_pkg::HIT_SECOND;
    end else begin
      added = mhm_pkg::ADDED_W'(l1_latency) + mhm_pkg::ADDED_W'(memory_latency) +
              (l2_on ? mhm_pkg::ADDED_W'(l2_latency) : '0);
      level = mhm_pkg::HIT_NONE;
    end
  end

  assign total_sum = {1'b0, total_cycles} + (mhm_pkg::CYCLE_W + 1)'(added);

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.process) begin
      hit_level    <= level;
      cycles_added <= added;
    end
  end

  // Running totals, saturating.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_cycles  <= '0;
      first_hits    <= '0;
      first_misses  <= '0;
      second_hits   <= '0;
      second_misses <= '0;
    end else if (cmd.process) begin
      total_cycles <= total_sum[mhm_pkg::CYCLE_W] ? '1 : total_sum[mhm_pkg::CYCLE_W-1:0];
      if (hit1 && first_hits != '1) begin
        first_hits <= first_hits + 1'b1;
      end
      if (!hit1 && first_misses != '1) begin
        first_misses <= first_misses + 1'b1;
      end
      if (hit2 && second_hits != '1) begin
        second_hits <= second_hits + 1'b1;
      end
      if (l2_on && !hit1 && !hit2 && second_misses != '1) begin
        second_misses <= second_misses + 1'b1;
      end
    end
  end

endmodule

>>> design/multilevel_cache_hit_miss_model.sv
// Top level of the two-level set-associative cache hit/miss model.
//
// Usage: raise start with byte_address; the transfer happens at a rising edge
// where start is high and busy is low. busy is then high for one cycle while
// the set rows of both levels, read from on-chip memory at the accept edge,
// are checked and written back. In the cycle after that, done is high for
// exactly one cycle with hit_level, cycles_added and the running totals.
// A new access may be accepted at the edge that ends the done cycle, so
// accesses never overlap; each is one memory read and one write-back per set.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle. Reset (rst, synchronous) restores the register defaults,
// clears the totals and marks every set row empty at once; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
module multilevel_cache_hit_miss_model (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mhm_pkg::ADDR_W-1:0]          byte_address,
  input  logic                                cfg_write,
  input  logic [2:0]                          cfg_index,
  input  logic [mhm_pkg::CFG_W-1:0]           cfg_data,
  output logic                                done,
  output logic [1:0]                          hit_level,
  output logic [mhm_pkg::ADDED_W-1:0]         cycles_added,
  output logic [mhm_pkg::CYCLE_W-1:0]         total_cycles,
  output logic [mhm_pkg::COUNT_W-1:0]         first_hits,
  output logic [mhm_pkg::COUNT_W-1:0]         first_misses,
  output logic [mhm_pkg::COUNT_W-1:0]         second_hits,
  output logic [mhm_pkg::COUNT_W-1:0]         second_misses
);

  mhm_pkg::cmd_t cmd;

  // Sequencing.
  mhm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Storage and arithmetic.
  mhm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .byte_address  (byte_address),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .hit_level     (hit_level),
    .cycles_added  (cycles_added),
    .total_cycles  (total_cycles),
    .first_hits    (first_hits),
    .first_misses  (first_misses),
    .second_hits   (second_hits),
    .second_misses (second_misses)
  );

endmodule

>>> design/mhm_checker.sv
// Port-level checker for the cache model, bound to the top level.
`include "assert_macros.svh"

module mhm_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] hit_level
);

  // An accepted transfer occupies the block for the following cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // Every busy cycle produces exactly one result in the next cycle.
  `ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  // A result only follows a busy cycle.
  `ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy))
  // The hit level code is always meaningful.
  `ASSERT_NOW(a_level_code, clk, rst, done, hit_level != 2'd3)

endmodule

bind multilevel_cache_hit_miss_model mhm_checker u_mhm_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .hit_level (hit_level)
);
